// ===== hw/rtl/obm_pkg.sv =====
// Package for the single-wire bus master: tick-count width, register indexes,
// register reset values, command codes, sequencer phases and helpers.
// No dependencies.
package obm_pkg;

  // Width of all tick counters and timing registers.
  localparam int TIME_BITS = 10;

  // Width of the configuration data port and number of registers.
  localparam int CFG_W    = 10;
  localparam int NUM_REGS = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);

  // Stream word widths: fields padded to whole bytes.
  localparam int IN_W  = 16;
  localparam int OUT_W = 16;

  typedef logic [TIME_BITS-1:0] time_t;

  // Register indexes on the configuration port.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_RESET_RECOV   = 3'd2,
    REG_WRITE_ONE_LOW = 3'd3,
    REG_WRITE_ZERO_LOW = 3'd4,
    REG_READ_LOW      = 3'd5,
    REG_READ_SAMPLE   = 3'd6,
    REG_SLOT_LEN      = 3'd7
  } reg_idx_t;

  // Reset values of the timing registers, in microsecond ticks.
  localparam int REG_INIT [NUM_REGS] = '{480, 70, 410, 6, 60, 6, 15, 70};

  // Command codes carried in the op field.
  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Sequencer phases.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_RLOW,
    PH_RWAIT,
    PH_RREC,
    PH_SLOT
  } phase_t;

  // One result word; the last field sits lowest when packed into tdata.
  typedef struct packed {
    logic       presence;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       drive_low;
  } result_t;

  // A duration or sample point of zero behaves as one tick.
  function automatic time_t at_least_one(input time_t v);
    at_least_one = (v == '0) ? time_t'(1) : v;
  endfunction

endpackage

// ===== hw/rtl/onewire_bus_master.sv =====
// Top level of the single-wire bus master: tick sequencer, timing registers
// and result register. Depends on obm_pkg.
//
// Each input word is one microsecond tick and produces exactly one result word.
// A word is taken on every clock in which the result register is empty or is
// being emptied, so the block runs at one tick per clock; the sequencer update
// is a single pass of logic between the state registers and the result register.
// While idle, a nonzero op starts a reset (low pulse, presence sample, recovery),
// a byte write or a byte read, least significant bit first, one bit per slot.
// Commands that arrive while busy are dropped. Timing registers may be written
// only while no command is in progress.
module onewire_bus_master (
  input  logic                             clk,
  input  logic                             rst,
  // Input stream: op [1:0], data_byte [9:2], line_level [10], zero pad above.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [obm_pkg::IN_W-1:0]         s_tdata,
  // Result stream: drive_low [0], busy_res [1], done_res [2], read_data [10:3],
  // presence [11], zero pad above.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [obm_pkg::OUT_W-1:0]        m_tdata,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [obm_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [obm_pkg::CFG_W-1:0]        cfg_data
);

  // Timing registers.
  obm_pkg::time_t cfg_q [obm_pkg::NUM_REGS];

  // Sequencer state.
  obm_pkg::phase_t phase_q, phase_next;
  obm_pkg::time_t  cnt_q, cnt_next;
  logic [2:0]      bit_q, bit_next;
  logic [7:0]      shift_q, shift_next;
  obm_pkg::op_t    op_q, op_next;
  logic            presence_q, presence_next;
  logic [7:0]      last_read_q, last_read_next;

  // Result register.
  obm_pkg::result_t res_q, res_next;
  logic             res_valid_q;

  // Input word fields.
  obm_pkg::op_t in_op;
  logic [7:0]   in_data;
  logic         in_line;

  // State as seen after a possible command start on this tick.
  logic            start;
  obm_pkg::phase_t eff_phase;
  obm_pkg::op_t    eff_op;
  logic [7:0]      eff_shift;

  // Effective timing values and comparisons.
  obm_pkg::time_t len_rlow, len_rwait, len_rrec, len_slot;
  obm_pkg::time_t low_one, low_zero, low_read, samp_raw, samp_pt, low_time;
  logic [obm_pkg::TIME_BITS:0] cnt_inc;
  logic            phase_end;
  logic            sample_hit;
  logic [7:0]      shift_upd;
  logic            s_accept;

  assign s_accept = s_tvalid && s_tready;
  assign s_tready = !res_valid_q || m_tready;

  assign in_op   = obm_pkg::op_t'(s_tdata[1:0]);
  assign in_data = s_tdata[9:2];
  assign in_line = s_tdata[10];

  // Command start: only from idle, and it takes effect on the same tick.
  assign start     = (phase_q == obm_pkg::PH_IDLE) && (in_op != obm_pkg::OP_NONE);
  assign eff_op    = start ? in_op : op_q;
  assign eff_phase = !start ? phase_q :
                     (in_op == obm_pkg::OP_RESET) ? obm_pkg::PH_RLOW : obm_pkg::PH_SLOT;
  assign eff_shift = !start ? shift_q :
                     (in_op == obm_pkg::OP_WRITE) ? in_data : 8'd0;
  // A fresh command always begins at tick zero of bit zero.

  // Durations with the zero-acts-as-one rule applied.
  assign len_rlow  = obm_pkg::at_least_one(cfg_q[obm_pkg::REG_RESET_LOW]);
  assign len_rwait = obm_pkg::at_least_one(cfg_q[obm_pkg::REG_PRESENCE_WAIT]);
  assign len_rrec  = obm_pkg::at_least_one(cfg_q[obm_pkg::REG_RESET_RECOV]);
  assign len_slot  = obm_pkg::at_least_one(cfg_q[obm_pkg::REG_SLOT_LEN]);
  assign low_one   = obm_pkg::at_least_one(cfg_q[obm_pkg::REG_WRITE_ONE_LOW]);
  assign low_zero  = obm_pkg::at_least_one(cfg_q[obm_pkg::REG_WRITE_ZERO_LOW]);
  assign low_read  = obm_pkg::at_least_one(cfg_q[obm_pkg::REG_READ_LOW]);
  assign samp_raw  = obm_pkg::at_least_one(cfg_q[obm_pkg::REG_READ_SAMPLE]);
  // A sample point past the slot is clamped to the last slot tick.
  assign samp_pt   = (samp_raw > len_slot - obm_pkg::time_t'(1)) ?
                     len_slot - obm_pkg::time_t'(1) : samp_raw;

  logic [2:0]     eff_bit;
  obm_pkg::time_t eff_cnt;
  assign eff_bit = start ? 3'd0 : bit_q;
  assign eff_cnt = start ? '0 : cnt_q;

  assign low_time = (eff_op == obm_pkg::OP_READ) ? low_read :
                    eff_shift[eff_bit] ? low_one : low_zero;

  assign cnt_inc    = {1'b0, eff_cnt} + {{obm_pkg::TIME_BITS{1'b0}}, 1'b1};
  assign sample_hit = (eff_phase == obm_pkg::PH_SLOT) && (eff_op == obm_pkg::OP_READ) &&
                      (eff_cnt == samp_pt);
  assign shift_upd  = sample_hit ? (eff_shift | (8'(in_line) << eff_bit)) : eff_shift;

  // End of the current phase or slot on this tick.
  always_comb begin
    case (eff_phase)
      obm_pkg::PH_RLOW:  phase_end = cnt_inc >= {1'b0, len_rlow};
      obm_pkg::PH_RWAIT: phase_end = cnt_inc >= {1'b0, len_rwait};
      obm_pkg::PH_RREC:  phase_end = cnt_inc >= {1'b0, len_rrec};
      obm_pkg::PH_SLOT:  phase_end = cnt_inc >= {1'b0, len_slot};
      default:           phase_end = 1'b0;
    endcase
  end

  // Next-state logic.
  always_comb begin
    phase_next     = eff_phase;
    cnt_next       = phase_end ? '0 : cnt_inc[obm_pkg::TIME_BITS-1:0];
    bit_next       = eff_bit;
    shift_next     = shift_upd;
    op_next        = eff_op;
    presence_next  = presence_q;
    last_read_next = last_read_q;
    case (eff_phase)
      obm_pkg::PH_IDLE: begin
        cnt_next   = '0;
      end
      obm_pkg::PH_RLOW: begin
        if (phase_end) phase_next = obm_pkg::PH_RWAIT;
      end
      obm_pkg::PH_RWAIT: begin
        if (phase_end) phase_next = obm_pkg::PH_RREC;
      end
      obm_pkg::PH_RREC: begin
        if (eff_cnt == '0) presence_next = !in_line;
        if (phase_end) phase_next = obm_pkg::PH_IDLE;
      end
      obm_pkg::PH_SLOT: begin
        if (phase_end) begin
          if (eff_bit == 3'd7) begin
            if (eff_op == obm_pkg::OP_READ) last_read_next = shift_upd;
            phase_next = obm_pkg::PH_IDLE;
            bit_next   = 3'd0;
          end else begin
            bit_next = eff_bit + 3'd1;
          end
        end
      end
      default: begin
        phase_next = obm_pkg::PH_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  // Output logic for the result word of this tick.
  always_comb begin
    res_next.drive_low = 1'b0;
    res_next.busy_res  = 1'b0;
    res_next.done_res  = 1'b0;
    case (eff_phase)
      obm_pkg::PH_IDLE: begin
        res_next.busy_res = 1'b0;
      end
      obm_pkg::PH_RLOW: begin
        res_next.busy_res  = 1'b1;
        res_next.drive_low = 1'b1;
      end
      obm_pkg::PH_RWAIT: begin
        res_next.busy_res = 1'b1;
      end
      obm_pkg::PH_RREC: begin
        res_next.busy_res = 1'b1;
        res_next.done_res = phase_end;
      end
      obm_pkg::PH_SLOT: begin
        res_next.busy_res  = 1'b1;
        res_next.drive_low = eff_cnt < low_time;
        res_next.done_res  = phase_end && (eff_bit == 3'd7);
      end
      default: begin
        res_next.busy_res = 1'b0;
      end
    endcase
    res_next.read_data = last_read_next;
    res_next.presence  = presence_next;
  end

  // Timing registers: reset values, then written from the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < obm_pkg::NUM_REGS; i++) begin
        cfg_q[i] <= obm_pkg::time_t'(obm_pkg::REG_INIT[i]);
      end
    end else if (cfg_we) begin
      cfg_q[cfg_index] <= obm_pkg::time_t'(cfg_data);
    end
  end

  // Sequencer state advances once per accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_q     <= obm_pkg::PH_IDLE;
      cnt_q       <= '0;
      bit_q       <= 3'd0;
      shift_q     <= 8'd0;
      op_q        <= obm_pkg::OP_NONE;
      presence_q  <= 1'b0;
      last_read_q <= 8'd0;
    end else if (s_accept) begin
      phase_q     <= phase_next;
      cnt_q       <= cnt_next;
      bit_q       <= bit_next;
      shift_q     <= shift_next;
      op_q        <= op_next;
      presence_q  <= presence_next;
      last_read_q <= last_read_next;
    end
  end

  // Result register: loaded with each accepted word, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid_q <= 1'b0;
    end else if (s_accept) begin
      res_valid_q <= 1'b1;
    end else if (m_tready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      res_q <= res_next;
    end
  end

  assign m_tvalid = res_valid_q;
  assign m_tdata  = {{(obm_pkg::OUT_W - $bits(obm_pkg::result_t)){1'b0}}, res_q};

`ifndef ASSERT_OFF
  // The bit index only moves inside a byte transfer.
  a_bit_idle: assert property (@(posedge clk) disable iff (rst)
    (phase_q != obm_pkg::PH_SLOT) |-> (bit_q == 3'd0))
    else $error("bit index nonzero outside a slot");

  // Without an accepted word the sequencer holds still.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !s_accept |=> ($stable(phase_q) && $stable(cnt_q) && $stable(bit_q)))
    else $error("sequencer moved without an accepted word");

  // A completing tick leaves the sequencer idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (s_accept && res_next.done_res) |=> (phase_q == obm_pkg::PH_IDLE))
    else $error("command completed but sequencer not idle");

  // A tick taken during a command reports busy.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_accept && phase_q != obm_pkg::PH_IDLE) |=> (m_tvalid && res_q.busy_res))
    else $error("tick during a command not reported busy");
`endif

endmodule

// ===== tb/sv/tb_onewire_bus_master.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the single-wire bus master: drives tick words,
// predicts every result word and compares it field by field.
// Depends on obm_pkg and onewire_bus_master.
module tb_onewire_bus_master;

  localparam int CYCLE_LIMIT = 30000;
  localparam int TICKS_PER_SET = 56;
  localparam int RANDOM_SETS = 12;

  // Kinds of timing register sets used across the run.
  localparam int SET_ZERO      = 0;
  localparam int SET_SHORT     = 1;
  localparam int SET_LONG_LOW  = 2;
  localparam int SET_RESET_MAX = 3;

  // Tick predictor and store of expected result words.
  class obm_tick_board;
    obm_pkg::time_t   timing [obm_pkg::NUM_REGS];
    obm_pkg::phase_t  ph;
    int unsigned      tick_cnt;
    int unsigned      bit_idx;
    logic [7:0]       shift_reg;
    obm_pkg::op_t     cmd;
    logic             pres_flag;
    logic [7:0]       read_byte;
    obm_pkg::result_t expected_q[$];
    int unsigned      mismatches;
    int unsigned      commands;
    int unsigned      completions;

    function void clear();
      for (int i = 0; i < obm_pkg::NUM_REGS; i++)
        timing[i] = obm_pkg::time_t'(obm_pkg::REG_INIT[i]);
      ph = obm_pkg::PH_IDLE;
      tick_cnt = 0;
      bit_idx = 0;
      shift_reg = '0;
      cmd = obm_pkg::OP_NONE;
      pres_flag = 1'b0;
      read_byte = '0;
    endfunction

    function void set_timing(obm_pkg::reg_idx_t idx, obm_pkg::time_t v);
      timing[idx] = v;
    endfunction

    // A zero duration counts as one tick.
    function int unsigned span(obm_pkg::reg_idx_t idx);
      return (timing[idx] == '0) ? 1 : int'(timing[idx]);
    endfunction

    function bit idle();
      return ph == obm_pkg::PH_IDLE;
    endfunction

    // Advance the sequencer by one accepted tick and queue its result word.
    function void take_tick(obm_pkg::op_t op, logic [7:0] data, logic line);
      int unsigned cnt;
      int unsigned slot;
      int unsigned lowt;
      int unsigned samp;
      obm_pkg::result_t r;
      r = '0;
      if (ph == obm_pkg::PH_IDLE && op != obm_pkg::OP_NONE) begin
        commands++;
        cmd = op;
        tick_cnt = 0;
        bit_idx = 0;
        if (op == obm_pkg::OP_RESET) begin
          ph = obm_pkg::PH_RLOW;
        end else begin
          ph = obm_pkg::PH_SLOT;
          shift_reg = (op == obm_pkg::OP_WRITE) ? data : 8'h00;
        end
      end
      cnt = tick_cnt;
      case (ph)
        obm_pkg::PH_RLOW: begin
          r.busy_res = 1'b1;
          r.drive_low = 1'b1;
          if (cnt + 1 >= span(obm_pkg::REG_RESET_LOW)) begin
            ph = obm_pkg::PH_RWAIT;
            cnt = 0;
          end else cnt++;
        end
        obm_pkg::PH_RWAIT: begin
          r.busy_res = 1'b1;
          if (cnt + 1 >= span(obm_pkg::REG_PRESENCE_WAIT)) begin
            ph = obm_pkg::PH_RREC;
            cnt = 0;
          end else cnt++;
        end
        obm_pkg::PH_RREC: begin
          r.busy_res = 1'b1;
          // Presence is a low line on the first recovery tick.
          if (cnt == 0) pres_flag = !line;
          if (cnt + 1 >= span(obm_pkg::REG_RESET_RECOV)) begin
            ph = obm_pkg::PH_IDLE;
            cnt = 0;
            r.done_res = 1'b1;
          end else cnt++;
        end
        obm_pkg::PH_SLOT: begin
          slot = span(obm_pkg::REG_SLOT_LEN);
          r.busy_res = 1'b1;
          if (cmd == obm_pkg::OP_READ) begin
            // A sample point past the slot falls on its last tick.
            samp = span(obm_pkg::REG_READ_SAMPLE);
            if (samp > slot - 1) samp = slot - 1;
            lowt = span(obm_pkg::REG_READ_LOW);
            if (cnt == samp) shift_reg[bit_idx] = shift_reg[bit_idx] | line;
          end else begin
            lowt = shift_reg[bit_idx] ? span(obm_pkg::REG_WRITE_ONE_LOW) :
                                        span(obm_pkg::REG_WRITE_ZERO_LOW);
          end
          r.drive_low = (cnt < lowt);
          if (cnt + 1 >= slot) begin
            cnt = 0;
            if (bit_idx == 7) begin
              if (cmd == obm_pkg::OP_READ) read_byte = shift_reg;
              ph = obm_pkg::PH_IDLE;
              bit_idx = 0;
              r.done_res = 1'b1;
            end else begin
              bit_idx++;
            end
          end else begin
            cnt++;
          end
        end
        default: begin
        end
      endcase
      tick_cnt = cnt;
      r.read_data = read_byte;
      r.presence = pres_flag;
      expected_q.push_back(r);
    endfunction

    // Compare one result word with the oldest expectation.
    function void check_result(obm_pkg::result_t got);
      obm_pkg::result_t want;
      if (expected_q.size() == 0) begin
        $error("result word arrived with no tick waiting: %h", got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (want.done_res) completions++;
      if (got.drive_low !== want.drive_low) begin
        $error("drive_low: expected %0d, got %0d", want.drive_low, got.drive_low);
        mismatches++;
      end
      if (got.busy_res !== want.busy_res) begin
        $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
        mismatches++;
      end
      if (got.done_res !== want.done_res) begin
        $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
        mismatches++;
      end
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %h, got %h", want.read_data, got.read_data);
        mismatches++;
      end
      if (got.presence !== want.presence) begin
        $error("presence: expected %0d, got %0d", want.presence, got.presence);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [obm_pkg::IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [obm_pkg::OUT_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [obm_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [obm_pkg::CFG_W-1:0] cfg_data = '0;

  obm_tick_board sb;
  int unsigned send_gap_pct = 10;
  int unsigned stall_pct = 62;
  int unsigned tick_total = 0;
  int unsigned set_total = 0;
  int unsigned cycle_cnt = 0;
  obm_pkg::time_t timing_set [obm_pkg::NUM_REGS];

  onewire_bus_master dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver side: random back-pressure at the current stall rate.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Every accepted result word goes to the scoreboard.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(obm_pkg::result_t'(m_tdata[11:0]));
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one tick word, after an optional gap, and hold it until accepted.
  task automatic send_tick(obm_pkg::op_t op, logic [7:0] data, logic line);
    if ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, line, data, op};
    do @(posedge clk); while (!s_tready);
    sb.take_tick(op, data, line);
    tick_total++;
  endtask

  // Commands start mostly from idle; some arrive while busy and get dropped.
  task automatic random_tick();
    obm_pkg::op_t op;
    if (sb.idle())
      op = ($urandom_range(99) < 30) ? obm_pkg::op_t'($urandom_range(1, 3)) :
                                       obm_pkg::OP_NONE;
    else
      op = ($urandom_range(99) < 15) ? obm_pkg::op_t'($urandom_range(1, 3)) :
                                       obm_pkg::OP_NONE;
    send_tick(op, 8'($urandom), 1'($urandom));
  endtask

  // Keep ticking until the running command has completed.
  task automatic finish_command();
    while (!sb.idle()) random_tick();
  endtask

  // Stop sending and wait for every expected word, plus some slack.
  task automatic drain(int extra);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Fill timing_set for one kind of register setting.
  function automatic void build_set(int kind);
    int unsigned slot;
    slot = $urandom_range(0, 12);
    timing_set[obm_pkg::REG_RESET_LOW]      = obm_pkg::time_t'($urandom_range(0, 12));
    timing_set[obm_pkg::REG_PRESENCE_WAIT]  = obm_pkg::time_t'($urandom_range(0, 12));
    timing_set[obm_pkg::REG_RESET_RECOV]    = obm_pkg::time_t'($urandom_range(0, 12));
    timing_set[obm_pkg::REG_SLOT_LEN]       = obm_pkg::time_t'(slot);
    timing_set[obm_pkg::REG_WRITE_ONE_LOW]  = obm_pkg::time_t'($urandom_range(0, slot + 2));
    timing_set[obm_pkg::REG_WRITE_ZERO_LOW] = obm_pkg::time_t'($urandom_range(0, slot + 2));
    timing_set[obm_pkg::REG_READ_LOW]       = obm_pkg::time_t'($urandom_range(0, slot + 2));
    timing_set[obm_pkg::REG_READ_SAMPLE]    = obm_pkg::time_t'($urandom_range(0, slot + 2));
    case (kind)
      SET_ZERO: begin
        for (int i = 0; i < obm_pkg::NUM_REGS; i++) timing_set[i] = '0;
      end
      SET_LONG_LOW: begin
        // Low times and the sample point run past the end of the slot.
        timing_set[obm_pkg::REG_WRITE_ONE_LOW]  = '1;
        timing_set[obm_pkg::REG_WRITE_ZERO_LOW] = '1;
        timing_set[obm_pkg::REG_READ_LOW]       = '1;
        timing_set[obm_pkg::REG_READ_SAMPLE]    = '1;
        timing_set[obm_pkg::REG_SLOT_LEN]       = obm_pkg::time_t'($urandom_range(1, 6));
      end
      SET_RESET_MAX: begin
        // The reset pulse runs the tick counter up to its top value.
        timing_set[obm_pkg::REG_RESET_LOW] = '1;
      end
      default: begin
      end
    endcase
  endfunction

  // Write all timing registers, one per clock, while the block is idle.
  task automatic apply_settings();
    for (int i = 0; i < obm_pkg::NUM_REGS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= obm_pkg::reg_idx_t'(i);
      cfg_data <= timing_set[i];
      sb.set_timing(obm_pkg::reg_idx_t'(i), timing_set[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    set_total++;
  endtask

  initial begin
    sb = new;
    sb.clear();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part with every register at zero, so each duration is one tick.
    build_set(SET_ZERO);
    apply_settings();
    // Reset that sees a device, then one that does not; commands while busy drop.
    send_tick(obm_pkg::OP_RESET, 8'h00, 1'b1);
    send_tick(obm_pkg::OP_NONE, 8'h00, 1'b1);
    send_tick(obm_pkg::OP_WRITE, 8'hA5, 1'b0);
    send_tick(obm_pkg::OP_RESET, 8'hFF, 1'b0);
    send_tick(obm_pkg::OP_READ, 8'h00, 1'b0);
    send_tick(obm_pkg::OP_NONE, 8'h00, 1'b1);
    // Writes of all ones and all zeros, then a read of an alternating pattern.
    for (int i = 0; i < 8; i++)
      send_tick(i == 0 ? obm_pkg::OP_WRITE : obm_pkg::op_t'($urandom_range(3)),
                8'hFF, 1'b1);
    for (int i = 0; i < 8; i++)
      send_tick(i == 0 ? obm_pkg::OP_WRITE : obm_pkg::op_t'($urandom_range(3)),
                8'h00, 1'b0);
    for (int i = 0; i < 8; i++)
      send_tick(i == 0 ? obm_pkg::OP_READ : obm_pkg::op_t'($urandom_range(3)),
                8'($urandom), i[0] ^ 1'b1);
    finish_command();
    drain(4);

    // Random part: one register setting per block of ticks, idle rates by thirds.
    for (int p = 1; p <= RANDOM_SETS; p++) begin
      if (p <= RANDOM_SETS / 3) begin
        send_gap_pct = 10;
        stall_pct = 62;
      end else if (p <= 2 * RANDOM_SETS / 3) begin
        send_gap_pct = 62;
        stall_pct = 10;
      end else begin
        send_gap_pct = 0;
        stall_pct = 0;
      end
      build_set((p % 4 == 2) ? SET_LONG_LOW : SET_SHORT);
      apply_settings();
      for (int n = 0; n < TICKS_PER_SET; n++) begin
        random_tick();
        // Once, let the result side catch up completely mid-stream.
        if (p == 6 && n == TICKS_PER_SET / 2) drain(0);
      end
      finish_command();
      drain(4);
    end

    // Longest reset low time: one full reset.
    build_set(SET_RESET_MAX);
    apply_settings();
    send_tick(obm_pkg::OP_RESET, 8'($urandom), 1'($urandom));
    finish_command();
    drain(4);

    $display("Run covered %0d ticks under %0d timing settings: %0d commands started,",
             tick_total, set_total, sb.commands);
    $display("%0d completed, %0d field mismatches.", sb.completions, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
